@@ sv/gbps_pkg.sv @@
// package: types and constants for the grid path solver
`default_nettype none
package gbps_pkg;
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_SOLVE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CELL_WALL = 2'd0,
		CELL_ROAD = 2'd1,
		CELL_STEP = 2'd2,
		CELL_BAD  = 2'd3
	} cell_t;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	localparam logic [11:0] COUNT_MAX = 12'd4095;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POP,
		ST_POPWAIT,
		ST_DIR,
		ST_DIRWAIT,
		ST_MARK,
		ST_MARKWAIT,
		ST_MARKSTEP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

@@ sv/gbps_if.sv @@
// interfaces: valid/ready channels for items and results
`default_nettype none
interface gbps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [5:0] cell_row;
	logic [5:0] cell_col;
	logic [1:0] write_value;
	modport source (output valid, opcode, cell_row, cell_col, write_value, input ready);
	modport sink (input valid, opcode, cell_row, cell_col, write_value, output ready);
endinterface

interface gbps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  read_value;
	logic        path_found;
	logic [11:0] marked_cells;
	modport source (output valid, read_value, path_found, marked_cells, input ready);
	modport sink (input valid, read_value, path_found, marked_cells, output ready);
endinterface
`default_nettype wire

@@ sv/grid_bfs_path_solver.sv @@
// top level: grid map store with an iterative breadth-first path solver
// write/read/no-op: result valid the cycle after acceptance, one per cycle while the result is taken
// solve: a clear pass over all GRID_SIDE*GRID_SIDE visited marks, then the search pops each
// queued cell and tries its four moves, then walks the path back and reports the result
// reset: clears control state, sets both size registers to 63, then a clear pass wipes the map
`default_nettype none
module grid_bfs_path_solver #(
	parameter int GRID_SIDE   = 64,
	parameter int QUEUE_DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	gbps_in_if.sink   in_ch,
	gbps_out_if.source out_ch
);
	import gbps_pkg::*;

	localparam int CB = $clog2(GRID_SIDE);
	localparam int AB = 2 * CB;
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int QB = $clog2(QUEUE_DEPTH);
	localparam int CAP = ((GRID_SIDE - 1) | 1) > 63 ? 63 : ((GRID_SIDE - 1) | 1);

	// the clear pass below also wipes the map once after reset
	logic [1:0]     map_mem [CELLS];
	logic           vis_mem [CELLS];
	logic [1:0]     dir_mem [CELLS];
	logic [AB-1:0]  q_mem   [QUEUE_DEPTH];

	logic [5:0] wreg_q, hreg_q;
	state_t     st_q, st_d;
	logic       boot_q;
	logic [AB:0] clr_q;
	logic [QB:0] head_q, tail_q;
	logic [CB:0] r_q, c_q;
	logic [1:0]  d_q;
	logic        found_q;
	logic [11:0] cnt_q;
	logic        ovalid_q;
	logic [1:0]  oread_q;
	logic        ofound_q;
	logic [11:0] ocnt_q;
	logic [1:0]  rd_map_q;
	logic        rd_vis_q;
	logic [1:0]  rd_dir_q;
	logic [AB-1:0] rd_q_q;
	logic        rdpend_q;

	// effective dimensions
	function automatic logic [5:0] eff(input logic [5:0] v);
		logic [5:0] x;
		x = v | 6'd1;
		if (x < 6'd3) x = 6'd3;
		if (x > 6'(CAP)) x = 6'(CAP);
		return x;
	endfunction

	logic [5:0] w_e, h_e;
	assign w_e = eff(wreg_q);
	assign h_e = eff(hreg_q);
	logic [CB:0] end_r, end_c;
	assign end_r = (CB+1)'(h_e) - (CB+1)'(2);
	assign end_c = (CB+1)'(w_e) - (CB+1)'(2);

	function automatic logic [AB-1:0] idx(input logic [CB:0] r, input logic [CB:0] c);
		return {r[CB-1:0], c[CB-1:0]};
	endfunction

	// neighbour of the current cell in direction d_q; signed wide arithmetic
	logic signed [CB+2:0] nr_s, nc_s;
	always_comb begin
		nr_s = $signed({2'b0, r_q});
		nc_s = $signed({2'b0, c_q});
		unique case (d_q)
			2'd0: nc_s = nc_s - $signed((CB+3)'(2));
			2'd1: nc_s = nc_s + $signed((CB+3)'(2));
			2'd2: nr_s = nr_s - $signed((CB+3)'(2));
			default: nr_s = nr_s + $signed((CB+3)'(2));
		endcase
	end
	logic nb_ok;
	assign nb_ok = (nr_s >= 0) && (nc_s >= 0) && (nr_s < $signed({3'b0, h_e}))
		&& (nc_s < $signed({3'b0, w_e}));
	logic [CB:0] nr, nc, mr, mc;
	assign nr = nr_s[CB:0];
	assign nc = nc_s[CB:0];
	assign mr = (CB+1)'((nr_s + $signed({2'b0, r_q})) >>> 1);
	assign mc = (CB+1)'((nc_s + $signed({2'b0, c_q})) >>> 1);

	// back-step from (r,c) using stored direction
	logic signed [CB+2:0] br_s, bc_s;
	always_comb begin
		br_s = $signed({2'b0, r_q});
		bc_s = $signed({2'b0, c_q});
		unique case (rd_dir_q)
			2'd0: bc_s = bc_s + $signed((CB+3)'(2));
			2'd1: bc_s = bc_s - $signed((CB+3)'(2));
			2'd2: br_s = br_s + $signed((CB+3)'(2));
			default: br_s = br_s - $signed((CB+3)'(2));
		endcase
	end
	logic bk_ok;
	assign bk_ok = (br_s >= 0) && (bc_s >= 0) && (br_s < $signed({3'b0, h_e}))
		&& (bc_s < $signed({3'b0, w_e}));

	logic in_acc;
	assign in_ch.ready = (st_q == ST_IDLE) && !boot_q && (!ovalid_q || out_ch.ready);
	assign in_acc = in_ch.valid && in_ch.ready;

	logic in_rng;
	assign in_rng = (in_ch.cell_row < h_e) && (in_ch.cell_col < w_e);

	// sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_acc && op_t'(in_ch.opcode) == OP_SOLVE) st_d = ST_CLEAR;
			ST_CLEAR: if (clr_q == (AB+1)'(CELLS - 1)) st_d = boot_q ? ST_IDLE : ST_POP;
			ST_POP: st_d = (head_q < tail_q) ? ST_POPWAIT : ST_OUT;
			ST_POPWAIT: st_d = ST_DIR;
			ST_DIR: st_d = ST_DIRWAIT;
			ST_DIRWAIT: st_d = ST_DIR;
			ST_MARK: st_d = ST_MARKWAIT;
			ST_MARKWAIT: st_d = ST_MARKSTEP;
			ST_MARKSTEP: st_d = ST_MARK;
			ST_OUT: if (!ovalid_q || out_ch.ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// branching states: dir completes after four moves, found jumps to marking,
	// walk ends at start or on an out-of-range back-step
	state_t st_fix;
	always_comb begin
		st_fix = st_d;
		if (st_q == ST_DIR && r_q == end_r && c_q == end_c) st_fix = ST_MARK;
		if (st_q == ST_DIRWAIT && d_q == 2'd3) st_fix = ST_POP;
		if (st_q == ST_MARKSTEP && ((r_q == 1 && c_q == 1) || !bk_ok)) st_fix = ST_OUT;
	end

	// a result transaction is loaded for every non-solve item and at the end of a solve
	logic set_ov;
	assign set_ov = (st_q == ST_IDLE && in_acc && op_t'(in_ch.opcode) != OP_SOLVE)
		|| (st_q == ST_OUT && (!ovalid_q || out_ch.ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			boot_q <= 1'b1;
			clr_q <= '0;
			wreg_q <= 6'd63;
			hreg_q <= 6'd63;
			head_q <= '0;
			tail_q <= '0;
			ovalid_q <= 1'b0;
			found_q <= 1'b0;
			rdpend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) wreg_q <= cfg_data;
				else hreg_q <= cfg_data;
			end
			if (set_ov) ovalid_q <= 1'b1;
			else if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			st_q <= st_fix;
			unique case (st_q)
				ST_IDLE: begin
					clr_q <= '0;
					if (in_acc)
						rdpend_q <= (op_t'(in_ch.opcode) == OP_READ) && in_rng;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AB+1)'(CELLS - 1)) begin
						boot_q <= 1'b0;
						head_q <= '0;
						tail_q <= (QB+1)'(1);
						found_q <= 1'b0;
					end
				end
				ST_POP: if (head_q < tail_q) head_q <= head_q + 1'b1;
				ST_POPWAIT: begin
					r_q <= (CB+1)'(rd_q_q[AB-1:CB]);
					c_q <= (CB+1)'(rd_q_q[CB-1:0]);
					d_q <= 2'd0;
				end
				ST_DIR: begin
					if (r_q == end_r && c_q == end_c) begin
						found_q <= 1'b1;
						cnt_q <= 12'd1;
					end
				end
				ST_DIRWAIT: begin
					if (nb_ok && !rd_vis_q && rd_map_q != CELL_WALL
						&& tail_q < (QB+1)'(QUEUE_DEPTH))
						tail_q <= tail_q + 1'b1;
					d_q <= d_q + 1'b1;
				end
				ST_MARKSTEP: begin
					if (!(r_q == 1 && c_q == 1) && bk_ok) begin
						if (cnt_q < COUNT_MAX - 12'd1) cnt_q <= cnt_q + 12'd2;
						else cnt_q <= COUNT_MAX;
						r_q <= br_s[CB:0];
						c_q <= bc_s[CB:0];
					end
				end
				default: ;
			endcase
		end
	end

	// memory accesses, selected by the sequencer state
	logic [AB-1:0] cur_a;
	assign cur_a = idx(r_q, c_q);
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (in_acc) begin
				if (op_t'(in_ch.opcode) == OP_WRITE && in_rng
					&& cell_t'(in_ch.write_value) != CELL_BAD)
					map_mem[idx((CB+1)'(in_ch.cell_row), (CB+1)'(in_ch.cell_col))]
						<= in_ch.write_value;
				rd_map_q <= map_mem[idx((CB+1)'(in_ch.cell_row), (CB+1)'(in_ch.cell_col))];
			end
			ST_CLEAR: begin
				vis_mem[clr_q[AB-1:0]] <=
					(clr_q[AB-1:0] == idx((CB+1)'(1), (CB+1)'(1))) && !boot_q;
				if (boot_q) map_mem[clr_q[AB-1:0]] <= CELL_WALL;
				q_mem[0] <= idx((CB+1)'(1), (CB+1)'(1));
			end
			ST_POP: rd_q_q <= q_mem[head_q[QB-1:0]];
			ST_DIR: begin
				rd_vis_q <= vis_mem[idx(nr, nc)];
				rd_map_q <= map_mem[idx(mr, mc)];
			end
			ST_DIRWAIT: if (nb_ok && !rd_vis_q && rd_map_q != CELL_WALL
				&& tail_q < (QB+1)'(QUEUE_DEPTH)) begin
				q_mem[tail_q[QB-1:0]] <= idx(nr, nc);
				vis_mem[idx(nr, nc)] <= 1'b1;
				dir_mem[idx(nr, nc)] <= d_q;
			end
			ST_MARK: begin
				map_mem[cur_a] <= CELL_STEP;
				rd_dir_q <= dir_mem[cur_a];
			end
			ST_MARKSTEP: if (!(r_q == 1 && c_q == 1) && bk_ok)
				map_mem[idx((CB+1)'((br_s + $signed({2'b0, r_q})) >>> 1),
					(CB+1)'((bc_s + $signed({2'b0, c_q})) >>> 1))] <= CELL_STEP;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_acc) begin
			oread_q <= 2'd0;
			ofound_q <= 1'b0;
			ocnt_q <= 12'd0;
		end
		if (st_q == ST_OUT && (!ovalid_q || out_ch.ready)) begin
			oread_q <= 2'd0;
			ofound_q <= found_q;
			ocnt_q <= found_q ? cnt_q : 12'd0;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.read_value = rdpend_q ? rd_map_q : oread_q;
	assign out_ch.path_found = ofound_q;
	assign out_ch.marked_cells = ocnt_q;
endmodule
`default_nettype wire

@@ test/grid_bfs_path_solver_tb.sv @@
// testbench for the grid path solver: map loads, reads and maze solves checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module grid_bfs_path_solver_tb;
	import gbps_pkg::*;

	// generous cycle limit: each solve costs a full clear pass plus the search
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SIDE        = 64;
	localparam int Q_DEPTH     = 1024;
	localparam int ITEM_TARGET = 1750;

	typedef struct packed {
		op_t        op;
		logic [5:0] row;
		logic [5:0] col;
		cell_t      val;
	} map_cmd_t;

	typedef struct packed {
		cell_t       rv;
		logic        found;
		logic [11:0] cnt;
	} answer_t;

	logic clk;
	logic arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [5:0] cfg_data;

	gbps_in_if  in_bus ();
	gbps_out_if out_bus ();

	grid_bfs_path_solver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_bus),
		.out_ch   (out_bus)
	);

	// shadow copy of the block's state and configuration
	cell_t       grid_map [SIDE*SIDE];
	bit          seen_mark [SIDE*SIDE];
	logic [1:0]  back_dir [SIDE*SIDE];
	int          bfs_fifo [Q_DEPTH];
	logic [5:0]  width_reg;
	logic [5:0]  height_reg;
	int          step_r [4] = '{0, 0, -2, 2};
	int          step_c [4] = '{-2, 2, 0, 0};

	map_cmd_t pending_cmds [$];
	answer_t  expected_answers [$];

	int  mismatches;
	int  items_queued;
	bit  no_idle;       // stretch with no idling on either side
	int  hold_req;      // bumped to ask the receiver for a long hold-off
	int  hold_seen;
	int  hold_left;
	int  tx_gap;
	int  rx_gap;
	int  cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(logic [5:0] r);
		int v;
		v = int'(r | 6'd1);
		if (v < 3)
			v = 3;
		return v;
	endfunction

	// breadth-first search from (1,1) to (h-2,w-2), then mark the path back as step
	task automatic solve_maze(input int w, input int h, inout answer_t a);
		int er, ec, cr, cc, nr, nc, ni, idx, pr, pc, d, cnt, guard, head, tail;
		bit found;
		er = h - 2;
		ec = w - 2;
		found = 0;
		foreach (seen_mark[i])
			seen_mark[i] = 0;
		head = 0;
		tail = 0;
		bfs_fifo[tail++] = SIDE + 1;
		seen_mark[SIDE + 1] = 1;
		while (head < tail) begin
			idx = bfs_fifo[head++];
			cr = idx / SIDE;
			cc = idx % SIDE;
			if (cr == er && cc == ec) begin
				found = 1;
				break;
			end
			for (d = 0; d < 4; d++) begin
				nr = cr + step_r[d];
				nc = cc + step_c[d];
				if (nr < 0 || nr >= h || nc < 0 || nc >= w)
					continue;
				ni = nr * SIDE + nc;
				if (seen_mark[ni])
					continue;
				if (grid_map[((nr + cr) / 2) * SIDE + (nc + cc) / 2] == CELL_WALL)
					continue;
				// queue full: move dropped, cell stays unvisited
				if (tail >= Q_DEPTH)
					continue;
				bfs_fifo[tail++] = ni;
				seen_mark[ni] = 1;
				back_dir[ni] = d[1:0];
			end
		end
		if (found) begin
			cr = er;
			cc = ec;
			cnt = 1;
			guard = 0;
			grid_map[cr * SIDE + cc] = CELL_STEP;
			while (!(cr == 1 && cc == 1) && guard < SIDE * SIDE) begin
				d = back_dir[cr * SIDE + cc];
				pr = cr - step_r[d];
				pc = cc - step_c[d];
				if (pr < 0 || pr >= h || pc < 0 || pc >= w)
					break;
				grid_map[((pr + cr) / 2) * SIDE + (pc + cc) / 2] = CELL_STEP;
				grid_map[pr * SIDE + pc] = CELL_STEP;
				cnt += 2;
				cr = pr;
				cc = pc;
				guard++;
			end
			if (cnt > int'(COUNT_MAX))
				cnt = COUNT_MAX;
			a.found = 1'b1;
			a.cnt = cnt[11:0];
		end
	endtask

	// work out the answer to one accepted transaction and queue it
	task automatic predict_answer(input map_cmd_t it);
		answer_t a;
		int w, h;
		a = '{CELL_WALL, 1'b0, 12'd0};
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		case (it.op)
			OP_WRITE: begin
				if (int'(it.row) < h && int'(it.col) < w && it.val != CELL_BAD)
					grid_map[it.row * SIDE + it.col] = it.val;
			end
			OP_READ: begin
				if (int'(it.row) < h && int'(it.col) < w)
					a.rv = grid_map[it.row * SIDE + it.col];
			end
			OP_SOLVE: solve_maze(w, h, a);
			default: ;
		endcase
		expected_answers.push_back(a);
	endtask

	task automatic report_bad(input string what, input int exp_v, input int got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
	endtask

	// sender: one transaction per accepted item, random gap drawn after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_bus.valid && in_bus.ready) begin
				predict_answer(pending_cmds.pop_front());
				tx_gap = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (in_bus.valid && !in_bus.ready) begin
				// hold the offer until taken
			end else if (tx_gap > 0) begin
				tx_gap--;
				in_bus.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				in_bus.valid       <= 1'b1;
				in_bus.opcode      <= pending_cmds[0].op;
				in_bus.cell_row    <= pending_cmds[0].row;
				in_bus.cell_col    <= pending_cmds[0].col;
				in_bus.write_value <= pending_cmds[0].val;
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// receiver: checks each result transaction, random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			rx_gap = 0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				if (expected_answers.size() == 0) begin
					report_bad("unexpected result", 0, 1);
				end else begin
					e = expected_answers.pop_front();
					if (out_bus.read_value !== e.rv)
						report_bad("read_value", e.rv, out_bus.read_value);
					if (out_bus.path_found !== e.found)
						report_bad("path_found", e.found, out_bus.path_found);
					if (out_bus.marked_cells !== e.cnt)
						report_bad("marked_cells", e.cnt, out_bus.marked_cells);
				end
				rx_gap = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_cmd(input op_t op, input int row, input int col, input cell_t val);
		map_cmd_t m;
		m.op  = op;
		m.row = row[5:0];
		m.col = col[5:0];
		m.val = val;
		pending_cmds.push_back(m);
		items_queued++;
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() > 0 || in_bus.valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only while the block is idle
	task automatic write_reg(input logic [0:0] idx, input logic [5:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		@(posedge clk);
	endtask

	// load a maze: nodes at odd/odd are road (one in ten step), links open with the given odds
	task automatic load_maze(input int open_pct);
		int w, h, r, c;
		cell_t v;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		for (r = 0; r < h; r++)
			for (c = 0; c < w; c++) begin
				if (r[0] && c[0])
					v = ($urandom_range(0, 9) == 0) ? CELL_STEP : CELL_ROAD;
				else if ((r[0] ^ c[0]) && r > 0 && c > 0 && r < h - 1 && c < w - 1)
					v = ($urandom_range(0, 99) < open_pct) ? CELL_ROAD : CELL_WALL;
				else
					v = CELL_WALL;
				queue_cmd(OP_WRITE, r, c, v);
			end
	endtask

	// noise: any opcode, any coordinate, any value
	task automatic queue_noise(input int n);
		repeat (n)
			queue_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
				$urandom_range(0, 63), cell_t'($urandom_range(0, 3)));
	endtask

	task automatic queue_reads(input int n);
		int w, h;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		repeat (n)
			queue_cmd(OP_READ, $urandom_range(0, h), $urandom_range(0, w), CELL_WALL);
	endtask

	initial begin
		int pick, wv, hv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = 6'd0;
		in_bus.valid = 1'b0;
		in_bus.opcode = OP_NOP;
		in_bus.cell_row = 6'd0;
		in_bus.cell_col = 6'd0;
		in_bus.write_value = CELL_WALL;
		out_bus.ready = 1'b0;
		width_reg = 6'd63;
		height_reg = 6'd63;
		foreach (grid_map[i])
			grid_map[i] = CELL_WALL;
		mismatches = 0;
		items_queued = 0;
		no_idle = 0;
		hold_req = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every opcode, the special cases
		queue_cmd(OP_READ, 0, 0, CELL_WALL);
		queue_cmd(OP_WRITE, 0, 0, CELL_ROAD);
		queue_cmd(OP_WRITE, 62, 62, CELL_STEP);
		queue_cmd(OP_WRITE, 63, 5, CELL_ROAD);       // row out of range, ignored
		queue_cmd(OP_WRITE, 5, 63, CELL_ROAD);       // column out of range, ignored
		queue_cmd(OP_WRITE, 1, 2, CELL_BAD);         // bad value, ignored
		queue_cmd(OP_READ, 0, 0, CELL_WALL);
		queue_cmd(OP_READ, 62, 62, CELL_WALL);
		queue_cmd(OP_READ, 63, 63, CELL_WALL);
		queue_cmd(OP_READ, 1, 2, CELL_WALL);
		queue_cmd(OP_NOP, 63, 63, CELL_BAD);
		queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);        // all walls: no path on full grid
		// start equals end on the smallest grid, even values round up
		write_reg(REG_WIDTH, 6'd0);
		write_reg(REG_HEIGHT, 6'd2);
		queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);
		queue_cmd(OP_READ, 1, 1, CELL_WALL);
		// long hold-off on the receiver while writes keep arriving
		write_reg(REG_WIDTH, 6'd63);
		write_reg(REG_HEIGHT, 6'd4);
		hold_req++;
		load_maze(100);
		queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);
		queue_reads(10);
		// sender pause until every result is back
		wait_idle();

		// random phases: mostly well-formed mazes on small grids
		while (items_queued < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				wv = 63;
				hv = $urandom_range(0, 9);
			end else if (pick == 1) begin
				wv = $urandom_range(0, 9);
				hv = 63;
			end else begin
				wv = $urandom_range(0, 15);
				hv = $urandom_range(0, 15);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			write_reg(REG_WIDTH, wv[5:0]);
			write_reg(REG_HEIGHT, hv[5:0]);
			if ($urandom_range(0, 4) == 0) begin
				queue_noise(40);
				queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);
			end else begin
				load_maze($urandom_range(30, 100));
				queue_noise(4);
				queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);
				queue_reads(12);
				if ($urandom_range(0, 1))
					queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);
			end
		end
		write_reg(REG_WIDTH, 6'd63);
		write_reg(REG_HEIGHT, 6'd63);
		queue_cmd(OP_SOLVE, 0, 0, CELL_WALL);

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
